/* src/windowed_min_delay_tracker_core_assert.svh */
// assertion macros for the windowed minimum delay tracker
// included by the rtl files that carry assertions; no other dependencies
`ifndef WINDOWED_MIN_DELAY_TRACKER_CORE_ASSERT_SVH
`define WINDOWED_MIN_DELAY_TRACKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define WMDT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wmdt assertion failed");
`define WMDT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("wmdt assertion failed");
`else
`define WMDT_ASSERT(lbl, clk, rst_n, prop)
`define WMDT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* src/wmdt_pkg.sv */
// shared types, constants and helpers for the windowed minimum delay tracker
// no dependencies
`default_nettype none

package wmdt_pkg;

    localparam int TIME_BITS      = 64;
    localparam int FIELD_BITS     = 64;
    localparam int CFG_BITS       = 32;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CMP_BITS       = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [1:0]           mode_t;
    typedef logic [CFG_BITS-1:0]  cfg_word_t;

    localparam mode_t MODE_INSERT = 2'd0;
    localparam mode_t MODE_QUERY  = 2'd1;
    localparam mode_t MODE_CLEAR  = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_BACK_LIMIT    = CFG_INDEX_BITS'(1);

    localparam cfg_word_t WINDOW_LENGTH_RESET = 32'd10000;
    localparam cfg_word_t BACK_LIMIT_RESET    = 32'd20000;

    // one slot: start time (zero means empty), best receive time, best delay
    typedef struct packed {
        time_t start;
        time_t recv;
        time_t delay;
    } slot_t;

    // registered input word with its delay already worked out
    typedef struct packed {
        mode_t mode;
        time_t now;
        time_t delta;
    } item_t;

    function automatic logic tnonneg(time_t d);
        return ~d[TIME_BITS-1];
    endfunction

endpackage

`default_nettype wire

/* src/wmdt_slot_update.sv */
// next-state logic of the two slots for insert and clear words
// depends on wmdt_pkg
`default_nettype none

module wmdt_slot_update (
    input  wire wmdt_pkg::item_t     item,
    input  wire wmdt_pkg::slot_t     cur_slot,
    input  wire wmdt_pkg::slot_t     prev_slot,
    input  wire wmdt_pkg::cfg_word_t window_length,
    output wmdt_pkg::slot_t          cur_slot_next,
    output wmdt_pkg::slot_t          prev_slot_next
);

    wmdt_pkg::slot_t fresh;
    wmdt_pkg::time_t since_start;
    wmdt_pkg::time_t delay_diff;
    logic            elapsed;
    logic            better;

    assign since_start = item.now - cur_slot.start;
    assign delay_diff  = cur_slot.delay - item.delta;
    assign elapsed     = wmdt_pkg::CMP_BITS'(since_start)
                         >= wmdt_pkg::CMP_BITS'(window_length);
    assign better      = wmdt_pkg::tnonneg(delay_diff);

    always_comb begin
        fresh.start    = item.now;
        fresh.recv     = item.now;
        fresh.delay    = item.delta;
        cur_slot_next  = cur_slot;
        prev_slot_next = prev_slot;
        case (item.mode)
            wmdt_pkg::MODE_INSERT: begin
                if (cur_slot.start == '0) begin
                    cur_slot_next = fresh;
                end else if (elapsed) begin
                    // window over: current slot ages into the previous one
                    prev_slot_next = cur_slot;
                    cur_slot_next  = fresh;
                end else if (better) begin
                    cur_slot_next.recv  = item.now;
                    cur_slot_next.delay = item.delta;
                end
            end
            wmdt_pkg::MODE_CLEAR: begin
                cur_slot_next  = '0;
                prev_slot_next = '0;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/wmdt_query.sv */
// query result: smaller of the current and the still valid previous minimum, or zero
// while the current slot is empty; depends on wmdt_pkg
`default_nettype none

module wmdt_query (
    input  wire wmdt_pkg::item_t     item,
    input  wire wmdt_pkg::slot_t     cur_slot,
    input  wire wmdt_pkg::slot_t     prev_slot,
    input  wire wmdt_pkg::cfg_word_t back_limit,
    output wmdt_pkg::time_t          min_delay
);

    wmdt_pkg::time_t age;
    wmdt_pkg::time_t delay_diff;
    logic            too_old;
    logic            use_prev;

    assign age        = item.now - prev_slot.recv;
    assign delay_diff = cur_slot.delay - prev_slot.delay;
    // a negative age never counts as too old
    assign too_old    = wmdt_pkg::tnonneg(age)
                        && (wmdt_pkg::CMP_BITS'(age) > wmdt_pkg::CMP_BITS'(back_limit));
    assign use_prev   = (prev_slot.start != '0) && !too_old
                        && wmdt_pkg::tnonneg(delay_diff);

    always_comb begin
        if (cur_slot.start == '0) begin
            min_delay = '0;
        end else if (use_prev) begin
            min_delay = prev_slot.delay;
        end else begin
            min_delay = cur_slot.delay;
        end
    end

endmodule

`default_nettype wire

/* src/windowed_min_delay_tracker_core.sv */
// top level of the windowed minimum delay tracker: input register, slot state,
// result register; uses wmdt_pkg, wmdt_slot_update, wmdt_query and the assert header
//
//  channel | direction | handshake         | contents
//  s_      | in        | s_tvalid/s_tready | tuser: mode; tdata: send time, local time
//  m_      | out       | m_tvalid/m_tready | tdata: min delay
//  cfg_    | in        | cfg_valid/ready   | register index and 32-bit data
//
// one word per cycle sustained while the result side keeps up; an accepted word sits in the
// input register, and a query result is then loaded into the output register, where it
// waits until m_tready takes it.
// reset empties both slots, loads the default window length and back limit and drops both
// valid flags; no word and no register write is taken while aresetn is low.
// a query held behind an untaken result stays in the input register and drops s_tready
// until m_tready rises; an insert or clear word in the input register never waits.
`default_nettype none
`include "windowed_min_delay_tracker_core_assert.svh"

module windowed_min_delay_tracker_core (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire [1:0]           s_tuser,    // [1:0] mode
    input  wire [127:0]         s_tdata,    // [63:0] remote_send_time, [127:64] local_time
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [63:0]         m_tdata,    // [63:0] min_delay
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [wmdt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire [wmdt_pkg::CFG_BITS-1:0]       cfg_data
);

    localparam int FB = wmdt_pkg::FIELD_BITS;
    localparam int TB = wmdt_pkg::TIME_BITS;

    wmdt_pkg::item_t     item_reg,  item_next;
    logic                in_valid_reg, in_valid_next;
    wmdt_pkg::slot_t     cur_slot_reg, cur_slot_next;
    wmdt_pkg::slot_t     prev_slot_reg, prev_slot_next;
    wmdt_pkg::slot_t     cur_upd, prev_upd;
    wmdt_pkg::cfg_word_t window_length_reg, window_length_next;
    wmdt_pkg::cfg_word_t back_limit_reg, back_limit_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [FB-1:0]       m_tdata_reg, m_tdata_next;
    wmdt_pkg::time_t     query_delay;
    wmdt_pkg::time_t     in_send;
    wmdt_pkg::time_t     in_now;
    logic                is_query;
    logic                stage_fire;
    logic                s_accept;
    logic                cfg_accept;

    assign in_send    = s_tdata[TB-1:0];
    assign in_now     = s_tdata[FB+TB-1:FB];
    assign is_query   = (item_reg.mode == wmdt_pkg::MODE_QUERY);
    assign stage_fire = in_valid_reg && (!is_query || !m_tvalid_reg || m_tready);
    assign s_tready   = aresetn && (!in_valid_reg || stage_fire);
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = aresetn;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    wmdt_slot_update u_slot_update (
        .item           (item_reg),
        .cur_slot       (cur_slot_reg),
        .prev_slot      (prev_slot_reg),
        .window_length  (window_length_reg),
        .cur_slot_next  (cur_upd),
        .prev_slot_next (prev_upd)
    );

    wmdt_query u_query (
        .item      (item_reg),
        .cur_slot  (cur_slot_reg),
        .prev_slot (prev_slot_reg),
        .back_limit(back_limit_reg),
        .min_delay (query_delay)
    );

    always_comb begin
        // delay of the incoming sample is formed ahead of the input register
        item_next.mode  = s_tuser;
        item_next.now   = in_now;
        item_next.delta = in_now - in_send;

        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (stage_fire) begin
            in_valid_next = 1'b0;
        end

        cur_slot_next  = cur_slot_reg;
        prev_slot_next = prev_slot_reg;
        if (stage_fire) begin
            cur_slot_next  = cur_upd;
            prev_slot_next = prev_upd;
        end

        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (stage_fire && is_query) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = FB'(query_delay);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        window_length_next = window_length_reg;
        back_limit_next    = back_limit_reg;
        if (cfg_accept) begin
            case (cfg_index)
                wmdt_pkg::REG_WINDOW_LENGTH: window_length_next = cfg_data;
                wmdt_pkg::REG_BACK_LIMIT:    back_limit_next    = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            m_tvalid_reg      <= 1'b0;
            cur_slot_reg      <= '0;
            prev_slot_reg     <= '0;
            window_length_reg <= wmdt_pkg::WINDOW_LENGTH_RESET;
            back_limit_reg    <= wmdt_pkg::BACK_LIMIT_RESET;
        end else begin
            in_valid_reg      <= in_valid_next;
            m_tvalid_reg      <= m_tvalid_next;
            cur_slot_reg      <= cur_slot_next;
            prev_slot_reg     <= prev_slot_next;
            window_length_reg <= window_length_next;
            back_limit_reg    <= back_limit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= item_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    `WMDT_ASSERT(a_stall_means_full, aclk, aresetn, !s_tready |-> in_valid_reg)
    `WMDT_ASSERT(a_query_loads_result, aclk, aresetn,
        (stage_fire && is_query) |=> m_tvalid_reg)
    `WMDT_ASSERT(a_empty_query_zero, aclk, aresetn,
        (stage_fire && is_query && cur_slot_reg.start == '0) |=> (m_tdata_reg == '0))
    `WMDT_ASSERT(a_clear_empties, aclk, aresetn,
        (stage_fire && item_reg.mode == wmdt_pkg::MODE_CLEAR)
        |=> (cur_slot_reg.start == '0 && prev_slot_reg.start == '0))

endmodule

`default_nettype wire
